// ===== rtl/rsfr_pkg.sv =====
package rsfr_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Default frame buffer length; a frame closes once BUF_LEN-1 bytes are counted.
  localparam int unsigned BUF_LEN = 256;

  // Input word kinds
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_FLAG = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK_GET   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK_SET   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADDR_ERR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CMD_ERR  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GET_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_CODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd3;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'd1;
  localparam logic [BYTE_W-1:0] GET_CODE_RST    = 8'd3;
  localparam logic [BYTE_W-1:0] SET_CODE_RST    = 8'd16;
  localparam logic [BYTE_W-1:0] GAP_TICKS_RST   = 8'd3;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] own_address;
    logic [BYTE_W-1:0] get_code;
    logic [BYTE_W-1:0] set_code;
    logic [BYTE_W-1:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   command_byte;
    logic [BYTE_W-1:0]   subcommand_byte;
    logic [BYTE_W-1:0]   frame_bytes;
    logic [BYTE_W-1:0]   error_streak;
    logic [TOTAL_W-1:0]  error_total;
  } result_t;

  // Nibble table of the reflected 0xA001 polynomial.
  function automatic logic [CRC_W-1:0] nib_val(input logic [3:0] n);
    logic [CRC_W-1:0] v;
    case (n)
      4'h0:    v = 16'h0000;
      4'h1:    v = 16'hCC01;
      4'h2:    v = 16'hD801;
      4'h3:    v = 16'h1400;
      4'h4:    v = 16'hF001;
      4'h5:    v = 16'h3C00;
      4'h6:    v = 16'h2800;
      4'h7:    v = 16'hE401;
      4'h8:    v = 16'hA001;
      4'h9:    v = 16'h6C00;
      4'hA:    v = 16'h7800;
      4'hB:    v = 16'hB401;
      4'hC:    v = 16'h5000;
      4'hD:    v = 16'h9C01;
      4'hE:    v = 16'h8801;
      default: v = 16'h4400;
    endcase
    return v;
  endfunction

  // One CRC-16/MODBUS byte update done as two nibble steps.
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    c = (c >> 4) ^ nib_val(c[3:0]);
    c = (c >> 4) ^ nib_val(c[3:0]);
    return c;
  endfunction

endpackage

// ===== rtl/rsfr_cfg.sv =====
module rsfr_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rsfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsfr_pkg::BYTE_W-1:0]        cfg_wdata,
  output rsfr_pkg::cfg_t                     cfg
);
  import rsfr_pkg::*;

  cfg_t cfg_r;

  // Register file, written by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address <= OWN_ADDRESS_RST;
      cfg_r.get_code    <= GET_CODE_RST;
      cfg_r.set_code    <= SET_CODE_RST;
      cfg_r.gap_ticks   <= GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_ADDRESS: cfg_r.own_address <= cfg_wdata;
        REG_GET_CODE:    cfg_r.get_code    <= cfg_wdata;
        REG_SET_CODE:    cfg_r.set_code    <= cfg_wdata;
        REG_GAP_TICKS:   cfg_r.gap_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/rsfr_core.sv =====
module rsfr_core #(
  parameter int unsigned BUF_LEN = rsfr_pkg::BUF_LEN
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsfr_pkg::cfg_t                cfg,
  input  logic                          step_en,
  input  logic [rsfr_pkg::OP_W-1:0]     op,
  input  logic [rsfr_pkg::BYTE_W-1:0]   data_byte,
  output logic                          res_valid,
  output rsfr_pkg::result_t             res
);
  import rsfr_pkg::*;

  // A frame closes once BUF_LEN-1 bytes are counted.
  localparam logic [BYTE_W-1:0] FULL_COUNT = BYTE_W'(BUF_LEN - 1);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]         phase_r, phase_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic [BYTE_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0]  gap_r, gap_nxt;
  logic [BYTE_W-1:0]  streak_r, streak_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [BYTE_W-1:0]  hdr_r [3];

  logic               hdr_we;
  logic [1:0]         hdr_idx;
  logic [STATUS_W-1:0] status;
  logic               is_err;
  logic [BYTE_W-1:0]  streak_upd;
  logic [TOTAL_W-1:0] total_upd;
  logic [BYTE_W-1:0]  gap_inc;
  logic [BYTE_W-1:0]  count_inc;

  // Frame verdict from the current state, used on a reporting tick.
  always_comb begin
    if (crc_r != '0) begin
      status = ST_CRC_ERR;
    end else if (hdr_r[0] != cfg.own_address) begin
      status = ST_ADDR_ERR;
    end else if (hdr_r[1] == cfg.get_code) begin
      status = ST_OK_GET;
    end else if (hdr_r[1] == cfg.set_code) begin
      status = ST_OK_SET;
    end else begin
      status = ST_CMD_ERR;
    end
    is_err     = (status == ST_CRC_ERR) || (status == ST_ADDR_ERR) ||
                 (status == ST_CMD_ERR);
    streak_upd = !is_err ? '0 : ((streak_r == '1) ? streak_r : streak_r + 8'd1);
    total_upd  = is_err ? total_r + {{(TOTAL_W-BYTE_W){1'b0}}, streak_upd} : total_r;
    gap_inc    = (gap_r == '1) ? gap_r : gap_r + 8'd1;
    count_inc  = count_r + 8'd1;
  end

  // Next state for one word.
  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    count_nxt  = count_r;
    gap_nxt    = gap_r;
    streak_nxt = streak_r;
    total_nxt  = total_r;
    hdr_we     = 1'b0;
    hdr_idx    = count_r[1:0];
    res_valid  = 1'b0;
    if (step_en) begin
      case (op)
        OP_BYTE, OP_FLAG: begin
          case (phase_r)
            PH_WAIT: begin
              // Any byte starts a frame, a flag on it is ignored.
              crc_nxt   = crc_step(CRC_INIT, data_byte);
              count_nxt = 8'd1;
              gap_nxt   = '0;
              hdr_we    = 1'b1;
              hdr_idx   = 2'd0;
              phase_nxt = PH_RECV;
            end
            PH_RECV: begin
              hdr_we = (count_r < 8'd3);
              if (op == OP_FLAG && crc_r == '0) begin
                phase_nxt = PH_DONE;
              end else begin
                crc_nxt   = crc_step(crc_r, data_byte);
                count_nxt = count_inc;
                gap_nxt   = '0;
                if (count_inc >= FULL_COUNT) begin
                  phase_nxt = PH_DONE;
                end
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (phase_r == PH_DONE) begin
            res_valid = 1'b1;
          end else if (phase_r == PH_RECV) begin
            gap_nxt = gap_inc;
            if (gap_inc >= cfg.gap_ticks) begin
              res_valid = 1'b1;
            end
          end
          if (res_valid) begin
            streak_nxt = streak_upd;
            total_nxt  = total_upd;
            phase_nxt  = PH_WAIT;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.status          = status;
  assign res.command_byte    = hdr_r[1];
  assign res.subcommand_byte = hdr_r[2];
  assign res.frame_bytes     = count_r;
  assign res.error_streak    = streak_upd;
  assign res.error_total     = total_upd;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      crc_r    <= CRC_INIT;
      count_r  <= '0;
      gap_r    <= '0;
      streak_r <= '0;
      total_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      count_r  <= count_nxt;
      gap_r    <= gap_nxt;
      streak_r <= streak_nxt;
      total_r  <= total_nxt;
    end
  end

  // Header bytes: address, command, subcommand.
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[hdr_idx] <= data_byte;
    end
  end

  // The byte count never passes the full-buffer mark.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("frame byte count past buffer end");

  // A result is only produced by a tick.
  a_res_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (step_en && op == OP_TICK))
    else $error("result without a tick");

  // After a report the receiver waits for the next frame.
  a_wait_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> phase_r == PH_WAIT)
    else $error("receiver not waiting after report");

  // A byte while waiting always opens a frame with a count of one.
  a_start_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && phase_r == PH_WAIT && (op == OP_BYTE || op == OP_FLAG))
    |=> (phase_r == PH_RECV && count_r == 8'd1))
    else $error("frame start not taken");

endmodule

// ===== rtl/rs485_slave_frame_receiver.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tuser: op; tdata: data_byte
// out_     out  out_tvalid/out_tready tuser: status; tdata: command .. error_total
// cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// One word is taken every cycle while out_ is free or out_tready is high; a word
// waits in the input register; its result, if any, is registered onto out_.
// The frame state updates in one pass of CRC nibble lookups and counter logic.
// rst_n is synchronous and active low; it clears control state and config.
// A result waiting on out_ stalls the input register only when out_tready is low.
module rs485_slave_frame_receiver #(
  parameter int unsigned BUF_LEN = rsfr_pkg::BUF_LEN
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  logic [1:0]                         in_tuser,   // [1:0] op
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [63:0]                        out_tdata,  // [7:0] command_byte,
                                                         // [15:8] subcommand_byte,
                                                         // [23:16] frame_bytes,
                                                         // [31:24] error_streak,
                                                         // [63:32] error_total
  output logic [2:0]                         out_tuser,  // [2:0] status
  // Configuration port
  input  logic                               cfg_we,
  input  logic [rsfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsfr_pkg::BYTE_W-1:0]        cfg_wdata
);
  import rsfr_pkg::*;

  cfg_t               cfg;
  logic               in_valid_r;
  logic [OP_W-1:0]    in_op_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               step_en;
  logic               res_valid;
  result_t            res;
  logic               out_valid_r;
  result_t            out_res_r;

  // The held word is processed when the result register can take its result.
  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  rsfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rsfr_core #(
    .BUF_LEN (BUF_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (step_en),
    .op        (in_op_r),
    .data_byte (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {out_res_r.error_total, out_res_r.error_streak,
                       out_res_r.frame_bytes, out_res_r.subcommand_byte,
                       out_res_r.command_byte};

endmodule
